// ===== rtl/core/ssum_pkg.sv =====
// ssum_pkg: shared types and constants for the sorted set union merger
// depends on nothing; imported by the top level, the checker and the testbench

package ssum_pkg;

  // fixed field widths of the command and result words
  localparam int unsigned IdxW  = 16;
  localparam int unsigned ModeW = 2;

  // command codes
  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ELEM  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MERGE = 2'd1,
    ST_READ  = 2'd2
  } state_e;

endpackage

// ===== rtl/core/sorted_set_union_merger.sv =====
// sorted_set_union_merger: top level, merge sequencer and two set banks
// depends on ssum_pkg and ssum_ram
//
// usage
//   a command word is taken when start_i is high and busy_o is low
//   mode clear empties the set and drops the overflow flag
//   mode element merges one index of an ascending list; stored entries below
//     it are copied into the other bank one per cycle, an equal entry is
//     absorbed, then the index is written; with last_in_list the remainder
//     is copied and the banks swap
//   mode read streams the stored set, one result word per cycle on
//     strobe_o, each word through the registered ram read and then the
//     output register; an empty set gives a single word with set_empty_o
//     high in the cycle after the command
//   the single ram read port of the source bank limits merges and readouts
//     to one stored entry per cycle
//   busy_o stays high while an element or a readout is in progress
//   result words are shown for exactly one cycle; the receiver cannot stall
//   reset empties the set and clears the flag; bank contents need no clearing

module sorted_set_union_merger
  import ssum_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [1:0]      mode_i,
  input  logic [IdxW-1:0] element_index_i,
  input  logic            last_in_list_i,
  output logic            strobe_o,
  output logic [IdxW-1:0] set_entry_o,
  output logic            is_last_o,
  output logic            set_empty_o,
  output logic            overflowed_o
);

  localparam int unsigned StoreW = (INDEX_BITS < IdxW) ? INDEX_BITS : IdxW;
  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   orp_q, orp_d;
  logic [CntW-1:0]   nwp_q, nwp_d;
  logic [CntW-1:0]   rdk_q, rdk_d;
  logic              bank_q, bank_d;
  logic              ovf_q, ovf_d;
  logic [StoreW-1:0] elem_q, elem_d;
  logic              last_q, last_d;
  logic              acc_q, acc_d;
  logic [StoreW-1:0] lastwr_q, lastwr_d;

  logic              strobe_q, strobe_d;
  logic [StoreW-1:0] entry_q, entry_d;
  logic              islast_q, islast_d;
  logic              empty_q, empty_d;
  logic              ovfout_q, ovfout_d;

  logic              put_en;
  logic [StoreW-1:0] put_val;
  logic              we_a, we_b;
  logic [AddrW-1:0]  waddr, raddr;
  logic [StoreW-1:0] rdata_a, rdata_b, src_data;
  logic [StoreW-1:0] in_elem;
  logic              have_old;
  logic              in_accept;

  assign in_elem   = element_index_i[StoreW-1:0];
  assign in_accept = start_i && (state_q == ST_IDLE);
  assign src_data  = bank_q ? rdata_b : rdata_a;
  assign have_old  = (orp_q < cnt_q);

  // sequencer: next state, positions and result word
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    orp_d    = orp_q;
    nwp_d    = nwp_q;
    rdk_d    = rdk_q;
    bank_d   = bank_q;
    ovf_d    = ovf_q;
    elem_d   = elem_q;
    last_d   = last_q;
    acc_d    = acc_q;
    lastwr_d = lastwr_q;
    strobe_d = 1'b0;
    entry_d  = entry_q;
    islast_d = islast_q;
    empty_d  = empty_q;
    ovfout_d = ovfout_q;
    put_en   = 1'b0;
    put_val  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              cnt_d = '0;
              orp_d = '0;
              nwp_d = '0;
              ovf_d = 1'b0;
            end
            MODE_ELEM: begin
              elem_d = in_elem;
              last_d = last_in_list_i;
              // an element not above the last written one is ignored
              acc_d  = !((nwp_q != '0) && (in_elem <= lastwr_q));
              if (acc_d || last_in_list_i) begin
                state_d = ST_MERGE;
              end
            end
            MODE_READ: begin
              if (cnt_q == '0) begin
                strobe_d = 1'b1;
                entry_d  = '0;
                islast_d = 1'b1;
                empty_d  = 1'b1;
                ovfout_d = ovf_q;
              end else begin
                rdk_d   = '0;
                state_d = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MERGE: begin
        if (acc_q) begin
          if (have_old && (src_data < elem_q)) begin
            // copy a smaller stored entry forward
            put_en  = 1'b1;
            put_val = src_data;
            orp_d   = orp_q + CntW'(1);
          end else begin
            // absorb an equal entry, then write the element
            if (have_old && (src_data == elem_q)) begin
              orp_d = orp_q + CntW'(1);
            end
            put_en  = 1'b1;
            put_val = elem_q;
            acc_d   = 1'b0;
            if (!last_q) begin
              state_d = ST_IDLE;
            end
          end
        end else if (have_old) begin
          // copy the remainder of the old set
          put_en  = 1'b1;
          put_val = src_data;
          orp_d   = orp_q + CntW'(1);
        end else begin
          // commit the merged set
          bank_d  = !bank_q;
          cnt_d   = nwp_q;
          orp_d   = '0;
          nwp_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_READ: begin
        strobe_d = 1'b1;
        entry_d  = src_data;
        islast_d = ((rdk_q + CntW'(1)) == cnt_q);
        empty_d  = 1'b0;
        ovfout_d = ovf_q;
        rdk_d    = rdk_q + CntW'(1);
        if (islast_d) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // write into the other bank, or drop past capacity
    if (put_en) begin
      if (nwp_q < CntW'(CAPACITY)) begin
        nwp_d    = nwp_q + CntW'(1);
        lastwr_d = put_val;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // ram ports
  assign waddr = nwp_q[AddrW-1:0];
  assign we_a  = put_en && (nwp_q < CntW'(CAPACITY)) && bank_q;
  assign we_b  = put_en && (nwp_q < CntW'(CAPACITY)) && !bank_q;
  assign raddr = (state_d == ST_READ) ? rdk_d[AddrW-1:0] : orp_d[AddrW-1:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      orp_q    <= '0;
      nwp_q    <= '0;
      rdk_q    <= '0;
      bank_q   <= 1'b0;
      ovf_q    <= 1'b0;
      acc_q    <= 1'b0;
      last_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      orp_q    <= orp_d;
      nwp_q    <= nwp_d;
      rdk_q    <= rdk_d;
      bank_q   <= bank_d;
      ovf_q    <= ovf_d;
      acc_q    <= acc_d;
      last_q   <= last_d;
      strobe_q <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    elem_q   <= elem_d;
    lastwr_q <= lastwr_d;
    entry_q  <= entry_d;
    islast_q <= islast_d;
    empty_q  <= empty_d;
    ovfout_q <= ovfout_d;
  end

  // set banks
  ssum_ram #(
    .Width (StoreW),
    .Depth (CAPACITY)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (put_val),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  ssum_ram #(
    .Width (StoreW),
    .Depth (CAPACITY)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (put_val),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  // outputs
  assign busy_o       = (state_q != ST_IDLE);
  assign strobe_o     = strobe_q;
  assign set_entry_o  = IdxW'(entry_q);
  assign is_last_o    = islast_q;
  assign set_empty_o  = empty_q;
  assign overflowed_o = ovfout_q;

endmodule

// ===== rtl/core/ssum_ram.sv =====
// ssum_ram: generic single write port, single read port ram, registered read
// depends on nothing

module ssum_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== verif/ssum_checker.sv =====
// ssum_checker: watches the command and result words of the sorted set union merger,
// predicts every readout and compares it field by field
// depends on ssum_pkg

module ssum_checker
  import ssum_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [1:0]      mode_i,
  input  logic [IdxW-1:0] element_index_i,
  input  logic            last_in_list_i,
  input  logic            strobe_i,
  input  logic [IdxW-1:0] set_entry_i,
  input  logic            is_last_i,
  input  logic            set_empty_i,
  input  logic            overflowed_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     words_checked_o,
  output int unsigned     overflow_words_o
);

  // one expected result word
  typedef struct packed {
    logic [IdxW-1:0] entry;
    logic            last;
    logic            empty;
    logic            ovf;
  } set_word_t;

  // shadow of the two banks and the merge positions
  logic [IdxW-1:0] bank [2][CAPACITY];
  bit              cur;
  int unsigned     set_count;
  int unsigned     old_pos;
  int unsigned     new_pos;
  bit              ovf_flag;

  set_word_t   readout_q [$];
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned overflow_words;
  int unsigned pending_words;

  assign fail_count_o     = mismatches;
  assign pending_o        = pending_words;
  assign words_checked_o  = words_checked;
  assign overflow_words_o = overflow_words;

  // write one entry into the bank being built, or drop it when full
  function automatic void put_merged(logic [IdxW-1:0] v);
    if (new_pos < CAPACITY) begin
      bank[cur ^ 1'b1][new_pos] = v;
      new_pos++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  // merge one list element; a non-ascending element is skipped but may still end the list
  function automatic void merge_element(logic [IdxW-1:0] e, logic fin);
    bit take;
    take = !(new_pos > 0 && e <= bank[cur ^ 1'b1][new_pos-1]);
    if (take) begin
      while (old_pos < set_count && bank[cur][old_pos] < e) begin
        put_merged(bank[cur][old_pos]);
        old_pos++;
      end
      if (old_pos < set_count && bank[cur][old_pos] == e) old_pos++;
      put_merged(e);
    end
    if (fin) begin
      while (old_pos < set_count) begin
        put_merged(bank[cur][old_pos]);
        old_pos++;
      end
      cur       = ~cur;
      set_count = new_pos;
      old_pos   = 0;
      new_pos   = 0;
    end
  endfunction

  // expected words of a readout of the committed set
  function automatic void queue_readout();
    set_word_t w;
    if (set_count == 0) begin
      w = '{entry: '0, last: 1'b1, empty: 1'b1, ovf: ovf_flag};
      readout_q.push_back(w);
    end else begin
      for (int unsigned k = 0; k < set_count; k++) begin
        w = '{entry: bank[cur][k], last: (k + 1 == set_count), empty: 1'b0, ovf: ovf_flag};
        readout_q.push_back(w);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [IdxW-1:0] want,
                                      logic [IdxW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare a result word with the oldest expectation
  function automatic void check_word();
    set_word_t w;
    if (readout_q.size() == 0) begin
      $display("%0t: result word with nothing expected: entry %0h last %b empty %b ovf %b",
               $time, set_entry_i, is_last_i, set_empty_i, overflowed_i);
      mismatches++;
    end else begin
      w = readout_q.pop_front();
      check_field("set_entry", w.entry, set_entry_i);
      check_field("is_last", IdxW'(w.last), IdxW'(is_last_i));
      check_field("set_empty", IdxW'(w.empty), IdxW'(set_empty_i));
      check_field("overflowed", IdxW'(w.ovf), IdxW'(overflowed_i));
      words_checked++;
      if (w.ovf) overflow_words++;
    end
  endfunction

  // results first, then the command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur       = 1'b0;
      set_count = 0;
      old_pos   = 0;
      new_pos   = 0;
      ovf_flag  = 1'b0;
      readout_q.delete();
      mismatches     = 0;
      words_checked  = 0;
      overflow_words = 0;
      pending_words  = 0;
    end else begin
      if (strobe_i === 1'b1) check_word();
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        case (mode_i)
          MODE_CLEAR: begin
            set_count = 0;
            old_pos   = 0;
            new_pos   = 0;
            ovf_flag  = 1'b0;
          end
          MODE_ELEM: merge_element(element_index_i, last_in_list_i);
          MODE_READ: queue_readout();
          default: ;
        endcase
      end
      pending_words = readout_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// testbench: drives command words into the sorted set union merger and gives the verdict
// depends on ssum_pkg, sorted_set_union_merger and ssum_checker

module testbench;
  import ssum_pkg::*;

  localparam int unsigned NumItems = 430;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            start_i         = 1'b0;
  logic [1:0]      mode_i          = MODE_NOP;
  logic [IdxW-1:0] element_index_i = '0;
  logic            last_in_list_i  = 1'b0;
  logic            busy_o;
  logic            strobe_o;
  logic [IdxW-1:0] set_entry_o;
  logic            is_last_o;
  logic            set_empty_o;
  logic            overflowed_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned overflow_words;

  int unsigned idle_pct;
  int unsigned n_clear;
  int unsigned n_elem;
  int unsigned n_read;
  int unsigned n_nop;

  sorted_set_union_merger i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .element_index_i(element_index_i),
    .last_in_list_i (last_in_list_i),
    .strobe_o       (strobe_o),
    .set_entry_o    (set_entry_o),
    .is_last_o      (is_last_o),
    .set_empty_o    (set_empty_o),
    .overflowed_o   (overflowed_o)
  );

  ssum_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .mode_i          (mode_i),
    .element_index_i (element_index_i),
    .last_in_list_i  (last_in_list_i),
    .strobe_i        (strobe_o),
    .set_entry_i     (set_entry_o),
    .is_last_i       (is_last_o),
    .set_empty_i     (set_empty_o),
    .overflowed_i    (overflowed_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .overflow_words_o(overflow_words)
  );

  always #5 clk_i = ~clk_i;

  // hand one command word over, with random idle cycles ahead of it
  task automatic send_word(mode_e m, logic [IdxW-1:0] idx, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    mode_i          <= m;
    element_index_i <= idx;
    last_in_list_i  <= fin;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    case (m)
      MODE_CLEAR: n_clear++;
      MODE_ELEM:  n_elem++;
      MODE_READ:  n_read++;
      default:    n_nop++;
    endcase
  endtask

  task automatic send_clear();
    send_word(MODE_CLEAR, IdxW'($urandom), 1'($urandom));
  endtask

  task automatic send_read();
    send_word(MODE_READ, IdxW'($urandom), 1'($urandom));
  endtask

  // one ascending list; with noise it may carry reads, ignored words,
  // out-of-order elements, an early clear or an out-of-order last element
  task automatic send_list(int unsigned len, int unsigned first, int unsigned step_max,
                           bit noisy);
    int unsigned vals [$];
    int unsigned v;
    int unsigned r;
    v = first;
    for (int unsigned i = 0; i < len && v <= 16'hFFFF; i++) begin
      vals.push_back(v);
      v += $urandom_range(step_max, 1);
    end
    foreach (vals[i]) begin
      r = noisy ? $urandom_range(99) : 100;
      if (r < 4 && i > 0) begin
        send_word(MODE_ELEM, IdxW'($urandom_range(vals[i-1], 0)), 1'b0);
      end else if (r < 9) begin
        send_read();
      end else if (r < 11) begin
        send_word(MODE_NOP, IdxW'($urandom), 1'($urandom));
      end else if (r < 12) begin
        send_clear();
        return;
      end else if (r < 14 && i > 0) begin
        send_word(MODE_ELEM, IdxW'($urandom_range(vals[i-1], 0)), 1'b1);
        return;
      end
      send_word(MODE_ELEM, IdxW'(vals[i]), i == vals.size() - 1);
    end
  endtask

  // stimulus
  initial begin
    int unsigned len;
    idle_pct = 30;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty readout, field extremes, duplicates, order breaks
    send_read();
    send_word(MODE_ELEM, 16'h0000, 1'b0);
    send_word(MODE_ELEM, 16'hFFFF, 1'b1);
    send_read();
    send_word(MODE_ELEM, 16'h0000, 1'b0);
    send_word(MODE_ELEM, 16'h0007, 1'b0);
    send_word(MODE_ELEM, 16'h0007, 1'b0);
    send_word(MODE_ELEM, 16'h0003, 1'b0);
    send_word(MODE_ELEM, 16'h5555, 1'b1);
    send_read();
    // readout and ignored word in the middle of a merge
    send_word(MODE_ELEM, 16'h0032, 1'b0);
    send_read();
    send_word(MODE_ELEM, 16'hAAAA, 1'b0);
    send_word(MODE_NOP, 16'hFFFF, 1'b1);
    send_word(MODE_ELEM, 16'hFFFF, 1'b1);
    send_read();
    // out-of-order last element still ends the merge
    send_word(MODE_ELEM, 16'h0001, 1'b0);
    send_word(MODE_ELEM, 16'h0000, 1'b1);
    send_read();
    // clear abandons a merge
    send_word(MODE_ELEM, 16'h00C8, 1'b0);
    send_clear();
    send_read();
    send_word(MODE_NOP, 16'h0000, 1'b0);

    // beyond capacity: the flag sticks until a clear
    idle_pct = 0;
    send_list($urandom_range(72, 66), $urandom_range(100), 3, 1'b0);
    send_read();
    send_word(MODE_ELEM, IdxW'($urandom), 1'b1);
    send_read();
    send_clear();
    send_read();

    // random part in idling phases
    while (n_clear + n_elem + n_read < NumItems) begin
      case (((n_clear + n_elem + n_read) * 4 / NumItems) % 4)
        0: idle_pct = 0;
        1: idle_pct = 54;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      case ($urandom_range(99)) inside
        [0:7]:   send_clear();
        [8:29]:  send_read();
        [30:32]: send_word(MODE_NOP, IdxW'($urandom), 1'($urandom));
        default: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(70, 30) : $urandom_range(12, 1);
          case ($urandom_range(2))
            0: send_list(len, $urandom_range(40), $urandom_range(6, 1), 1'b1);
            1: send_list(len, $urandom_range(16'hFFFF), $urandom_range(8000, 1), 1'b1);
            default: send_list(len, 16'hFFFF - $urandom_range(60), $urandom_range(3, 1), 1'b1);
          endcase
        end
      endcase
    end
    start_i <= 1'b0;
    @(posedge clk_i);

    // drain outstanding readouts, then let a last merge finish
    for (int i = 0; i < 5000 && pending != 0; i++) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (pending != 0) $display("%0t: %0d expected result words never arrived", $time, pending);
    $display("covered %0d commands: %0d elements, %0d reads, %0d clears, %0d ignored",
             n_clear + n_elem + n_read + n_nop, n_elem, n_read, n_clear, n_nop);
    $display("checked %0d result words, %0d of them with the overflow flag set",
             words_checked, overflow_words);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
